/* rtl/ps2_set1_key_decoder_macros.svh */
// Assertion macros for the PS/2 set 1 key decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PS2_SET1_KEY_DECODER_MACROS_SVH
`define PS2_SET1_KEY_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge while reset is released.
`define PS2K_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// The expression must never be true while reset is released.
`define PS2K_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define PS2K_ASSERT(label, clk, rstn, prop, msg)
`define PS2K_ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

/* rtl/ps2k_pkg.sv */
// Shared types, scancode constants and lookup functions for the PS/2 set 1 key decoder.
// No dependencies; used by ps2k_decode and ps2_set1_key_decoder.
`timescale 1ns / 1ps

package ps2k_pkg;

    // Input kinds carried on the slave-side tuser.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Set 1 scancodes with a fixed role.
    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_BREAK    = 8'h80;
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_CTRL     = 8'h1D;
    localparam logic [7:0] SC_ALT      = 8'h38;
    localparam logic [7:0] SC_CAPS     = 8'h3A;
    localparam logic [7:0] SC_LSHIFT_B = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_B = 8'hB6;
    localparam logic [7:0] SC_CTRL_B   = 8'h9D;
    localparam logic [7:0] SC_ALT_B    = 8'hB8;

    // Bases of the special key codes.
    localparam logic [8:0] EDIT_BASE = 9'h100;
    localparam logic [8:0] FKEY_BASE = 9'h070;

    // Held-key and prefix flags.
    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
        logic prefix;
    } ps2k_flags_t;

    // What one scancode produces.
    typedef struct packed {
        logic       ev;
        logic [8:0] key_code;
        logic [2:0] mods;
        logic       push;
        logic [6:0] push_char;
    } ps2k_dec_t;

    // US base character for a make code; zero where the key has no character.
    function automatic logic [6:0] base_char(input logic [6:0] sc);
        logic [6:0] ch;
        case (sc)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            7'h47: ch = 7'h37;
            7'h48: ch = 7'h38;
            7'h49: ch = 7'h39;
            7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34;
            7'h4C: ch = 7'h35;
            7'h4D: ch = 7'h36;
            7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31;
            7'h50: ch = 7'h32;
            7'h51: ch = 7'h33;
            7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // US shift mapping: symbol keys to their shifted symbols, letters to upper case.
    function automatic logic [6:0] shift_char(input logic [6:0] ch);
        logic [6:0] res;
        case (ch)
            7'h31: res = 7'h21;
            7'h32: res = 7'h40;
            7'h33: res = 7'h23;
            7'h34: res = 7'h24;
            7'h35: res = 7'h25;
            7'h36: res = 7'h5E;
            7'h37: res = 7'h26;
            7'h38: res = 7'h2A;
            7'h39: res = 7'h28;
            7'h30: res = 7'h29;
            7'h2D: res = 7'h5F;
            7'h3D: res = 7'h2B;
            7'h5B: res = 7'h7B;
            7'h5D: res = 7'h7D;
            7'h5C: res = 7'h7C;
            7'h3B: res = 7'h3A;
            7'h27: res = 7'h22;
            7'h60: res = 7'h7E;
            7'h2C: res = 7'h3C;
            7'h2E: res = 7'h3E;
            7'h2F: res = 7'h3F;
            default: begin
                if (ch >= 7'h61 && ch <= 7'h7A) begin
                    res = ch - 7'h20;
                end else begin
                    res = ch;
                end
            end
        endcase
        return res;
    endfunction

    // Special key code for arrow, edit and function keys; zero when none applies.
    function automatic logic [8:0] special_code(input logic [7:0] sc);
        logic [8:0] code;
        case (sc)
            8'h4B: code = EDIT_BASE + 9'd0;
            8'h4D: code = EDIT_BASE + 9'd1;
            8'h48: code = EDIT_BASE + 9'd2;
            8'h50: code = EDIT_BASE + 9'd3;
            8'h47: code = EDIT_BASE + 9'd4;
            8'h4F: code = EDIT_BASE + 9'd5;
            8'h49: code = EDIT_BASE + 9'd6;
            8'h51: code = EDIT_BASE + 9'd7;
            8'h53: code = EDIT_BASE + 9'd8;
            8'h52: code = EDIT_BASE + 9'd9;
            8'h3B: code = FKEY_BASE + 9'd0;
            8'h3C: code = FKEY_BASE + 9'd1;
            8'h3D: code = FKEY_BASE + 9'd2;
            8'h3E: code = FKEY_BASE + 9'd3;
            8'h3F: code = FKEY_BASE + 9'd4;
            8'h40: code = FKEY_BASE + 9'd5;
            8'h41: code = FKEY_BASE + 9'd6;
            8'h42: code = FKEY_BASE + 9'd7;
            8'h43: code = FKEY_BASE + 9'd8;
            8'h44: code = FKEY_BASE + 9'd9;
            8'h57: code = FKEY_BASE + 9'd10;
            8'h58: code = FKEY_BASE + 9'd11;
            default: code = 9'h000;
        endcase
        return code;
    endfunction

endpackage

/* rtl/ps2_set1_key_decoder.sv */
// PS/2 set 1 key decoder: takes one scancode byte or one console read request
// per clock while the result side keeps up, and returns one result per item.
// An accepted item is held in an input register, decoded in one pass and then
// loaded into the result register once that register is free or being taken.
// The character ring is a RAM of RING_DEPTH entries whose registered read port
// is loaded together with the result register; it holds at most RING_DEPTH-1
// characters, needs no clearing after reset, and a printable key that finds it
// full still gives its event but its character is dropped.
// Depends on ps2k_pkg, ps2k_decode, ps2k_ram and ps2_set1_key_decoder_macros.svh.
`timescale 1ns / 1ps

`include "ps2_set1_key_decoder_macros.svh"

module ps2_set1_key_decoder #(
    parameter int RING_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic        s_tuser,   // [0] opcode
    // Result transactions.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] key_code, [11:9] modifier_bits, [18:12] read_char
    output logic [1:0]  m_tuser    // [0] event_valid, [1] read_valid
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Decoder state and ring pointers.
    ps2k_pkg::ps2k_flags_t flags_reg, flags_next, dec_flags;
    ps2k_pkg::ps2k_dec_t   dec;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next, wr_inc;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next, rd_inc;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic       out_ev_reg;
    logic [8:0] out_code_reg;
    logic [2:0] out_mods_reg;
    logic       out_rd_hit_reg;
    logic [6:0] ram_q;

    logic advance, s_accept, is_scan, is_read, ring_empty, ring_full, push, pop;

    // Pipeline handshake: the input stage moves on when the result stage is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign is_scan = advance && (in_op_reg == ps2k_pkg::OP_SCAN);
    assign is_read = advance && (in_op_reg == ps2k_pkg::OP_READ);

    // Ring occupancy.
    assign wr_inc     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_inc     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign ring_full  = (wr_inc == rd_ptr_reg);
    assign push       = is_scan && dec.push && !ring_full;
    assign pop        = is_read && !ring_empty;

    ps2k_decode u_decode (
        .scan_byte  (in_byte_reg),
        .flags      (flags_reg),
        .flags_next (dec_flags),
        .dec        (dec)
    );

    ps2k_ram #(
        .WIDTH (7),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (dec.push_char),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_q)
    );

    // Next-state logic for control registers.
    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        flags_next     = is_scan ? dec_flags : flags_reg;
        wr_ptr_next    = push ? wr_inc : wr_ptr_reg;
        rd_ptr_next    = pop ? rd_inc : rd_ptr_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_ev_reg     <= is_scan && dec.ev;
            out_code_reg   <= is_scan ? dec.key_code : 9'h000;
            out_mods_reg   <= is_scan ? dec.mods : 3'b000;
            out_rd_hit_reg <= pop;
        end
    end

    // Result transaction; the popped character comes straight from the RAM read register.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_rd_hit_reg, out_ev_reg};
    assign m_tdata  = {5'b00000, (out_rd_hit_reg ? ram_q : 7'h00), out_mods_reg, out_code_reg};

    // A push never leaves the ring looking empty.
    `PS2K_ASSERT(a_push_not_empty, aclk, aresetn, push |=> (wr_ptr_reg != rd_ptr_reg), "ring overrun")
    // A pop always moves the read pointer.
    `PS2K_ASSERT(a_pop_moves, aclk, aresetn, pop |=> (rd_ptr_reg != $past(rd_ptr_reg)), "pop lost")
    // Flags change only when a scancode leaves the input stage.
    `PS2K_ASSERT(a_flags_hold, aclk, aresetn, !is_scan |=> $stable(flags_reg), "flags moved")
    // A result never carries both a key event and a popped character.
    `PS2K_ASSERT_NEVER(a_one_kind, aclk, aresetn, out_valid_reg && out_ev_reg && out_rd_hit_reg, "mixed result")

endmodule

/* rtl/ps2k_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ps2k_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ps2k_decode.sv */
// Scancode decoder: flag update, special key lookup and character mapping for one byte.
// Depends on ps2k_pkg.
`timescale 1ns / 1ps

module ps2k_decode (
    input  logic [7:0]           scan_byte,
    input  ps2k_pkg::ps2k_flags_t flags,
    output ps2k_pkg::ps2k_flags_t flags_next,
    output ps2k_pkg::ps2k_dec_t   dec
);

    logic [8:0] sp_code;
    logic [6:0] base;
    logic [6:0] mapped;
    logic [2:0] mods;

    assign sp_code = ps2k_pkg::special_code(scan_byte);
    assign base    = ps2k_pkg::base_char(scan_byte[6:0]);
    assign mods    = {flags.shift, flags.alt, flags.ctrl};

    // Shift takes precedence; otherwise caps lock raises letters only.
    always_comb begin
        if (flags.shift) begin
            mapped = ps2k_pkg::shift_char(base);
        end else if (flags.caps && base >= 7'h61 && base <= 7'h7A) begin
            mapped = base - 7'h20;
        end else begin
            mapped = base;
        end
    end

    // Byte classification and flag update.
    always_comb begin
        flags_next    = flags;
        dec           = '0;
        if (scan_byte == ps2k_pkg::SC_PREFIX) begin
            flags_next.prefix = 1'b1;
        end else begin
            flags_next.prefix = 1'b0;
            if (scan_byte == ps2k_pkg::SC_LSHIFT || scan_byte == ps2k_pkg::SC_RSHIFT) begin
                flags_next.shift = 1'b1;
            end else if (scan_byte == ps2k_pkg::SC_LSHIFT_B ||
                         scan_byte == ps2k_pkg::SC_RSHIFT_B) begin
                flags_next.shift = 1'b0;
            end else if (scan_byte == ps2k_pkg::SC_CTRL) begin
                flags_next.ctrl = 1'b1;
            end else if (scan_byte == ps2k_pkg::SC_CTRL_B) begin
                flags_next.ctrl = 1'b0;
            end else if (scan_byte == ps2k_pkg::SC_ALT) begin
                flags_next.alt = 1'b1;
            end else if (scan_byte == ps2k_pkg::SC_ALT_B) begin
                flags_next.alt = 1'b0;
            end else if (scan_byte == ps2k_pkg::SC_CAPS) begin
                // An extended caps make leaves the lock alone.
                if (!flags.prefix) begin
                    flags_next.caps = !flags.caps;
                end
            end else if ((scan_byte & ps2k_pkg::SC_BREAK) == 8'h00) begin
                if (sp_code != 9'h000) begin
                    dec.ev       = 1'b1;
                    dec.key_code = sp_code;
                    dec.mods     = mods;
                end else if (base != 7'h00) begin
                    dec.ev        = 1'b1;
                    dec.key_code  = {2'b00, mapped};
                    dec.mods      = mods;
                    dec.push      = 1'b1;
                    dec.push_char = mapped;
                end
            end
        end
    end

endmodule
